// ===== src/wildcard_byte_pattern_search_core_macros.svh =====
// Assertion macros for the wildcard byte pattern search core.
// Used by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_CORE_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_CORE_MACROS_SVH

// antecedent this cycle, consequent at the next edge
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// antecedent and consequent in the same cycle
`define WBPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/wbps_pkg.sv =====
// Package for the wildcard byte pattern search core: widths, codes, cell control.
// No dependencies.
package wbps_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 32;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned PIDX_W          = 5;
  localparam int unsigned PLEN_W          = 6;
  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 32;

  localparam logic [BYTE_W-1:0] WILDCARD = 8'hFF;

  localparam logic ACT_PATTERN = 1'b0;
  localparam logic ACT_DATA    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_OFFSET  = 1'b1;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic              shift;
    logic              pat_wr;
    logic [PIDX_W-1:0] wr_idx;
    logic [BYTE_W-1:0] wr_byte;
    logic [PLEN_W-1:0] len;
  } wbps_cell_ctrl_t;

endpackage

// ===== src/wbps_if.sv =====
// Channel interfaces of the wildcard byte pattern search core.
// Depends on wbps_pkg for field widths.
interface wbps_in_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [wbps_pkg::PIDX_W-1:0]    pattern_index;
  logic [wbps_pkg::BYTE_W-1:0]    byte_value;
  logic                           last;

  modport source (output valid, action, pattern_index, byte_value, last, input ready);
  modport sink   (input valid, action, pattern_index, byte_value, last, output ready);
endinterface

interface wbps_out_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [wbps_pkg::ADDR_W-1:0]    match_address;

  modport source (output valid, found, match_address, input ready);
  modport sink   (input valid, found, match_address, output ready);
endinterface

interface wbps_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [wbps_pkg::CFG_IDX_W-1:0]    index;
  logic [wbps_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/wildcard_byte_pattern_search_core.sv =====
// Wildcard byte pattern search core: chain of compare cells over a byte window.
// A result is in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle while no result is stalled; the cell chain shifts and compares together.
// Input stalls only while a result sits unclaimed in the output register.
// Synchronous active-low reset clears pattern, search state and both registers.
`include "wildcard_byte_pattern_search_core_macros.svh"

module wildcard_byte_pattern_search_core #(
  parameter int unsigned MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  wbps_in_if.sink    in_ch,
  wbps_out_if.source out_ch,
  wbps_cfg_if.sink   cfg_ch
);
  import wbps_pkg::*;

  localparam int unsigned IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned VEC_W  = MAX_PATTERN * BYTE_W;
  localparam int unsigned SH_W   = IDX_W + 3;

  logic [PLEN_W-1:0] len_r, len_nxt;
  logic [ADDR_W-1:0] offset_r, offset_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_inc;
  logic              done_r, done_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;

  logic              in_acc, is_data, data_step, hit, emit_found, emit_nf;
  logic [PLEN_W-1:0] len_eff;
  logic [IDX_W-1:0]  sh;
  logic [SH_W-1:0]   sh_bits;
  logic [VEC_W-1:0]  new_win, rev_win, al_win;
  logic [MAX_PATTERN-1:0] flags;
  logic [BYTE_W-1:0] win_q [MAX_PATTERN];
  logic [ADDR_W-1:0] start_addr;
  wbps_cell_ctrl_t   ctrl;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign is_data   = (in_ch.action == ACT_DATA);
  assign data_step = in_acc && is_data && !done_r;

  assign len_eff = (int'(len_r) > MAX_PATTERN) ? PLEN_W'(MAX_PATTERN) : len_r;

  always_comb begin
    ctrl         = '0;
    ctrl.shift   = data_step;
    ctrl.pat_wr  = in_acc && (in_ch.action == ACT_PATTERN);
    ctrl.wr_idx  = in_ch.pattern_index;
    ctrl.wr_byte = in_ch.byte_value;
    ctrl.len     = len_eff;
  end

  // window as it stands after this byte, newest at byte 0
  always_comb begin
    new_win[BYTE_W-1:0] = in_ch.byte_value;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      new_win[j*BYTE_W +: BYTE_W] = win_q[j-1];
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      rev_win[i*BYTE_W +: BYTE_W] = new_win[(MAX_PATTERN-1-i)*BYTE_W +: BYTE_W];
    end
  end

  // align so that cell k sees window byte len-1-k
  assign sh      = IDX_W'(MAX_PATTERN - int'(len_eff));
  assign sh_bits = {sh, 3'b000};
  assign al_win  = rev_win >> sh_bits;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [BYTE_W-1:0] cell_in;
    if (k == 0) begin : g_head
      assign cell_in = in_ch.byte_value;
    end else begin : g_body
      assign cell_in = win_q[k-1];
    end
    wbps_cell #(.CELL_IDX(k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .win_in  (cell_in),
      .al_byte (al_win[k*BYTE_W +: BYTE_W]),
      .win_out (win_q[k]),
      .flag    (flags[k])
    );
  end

  assign fill_inc = (fill_r == FILL_W'(MAX_PATTERN)) ? fill_r : fill_r + FILL_W'(1);

  assign hit = (len_eff == '0) || ((int'(fill_inc) >= int'(len_eff)) && (&flags));

  assign emit_found = data_step && hit;
  assign emit_nf    = data_step && !hit && in_ch.last;

  // empty pattern always reports start zero plus the result offset
  assign start_addr = (len_eff == '0) ? offset_r :
                      pos_r + offset_r + ADDR_W'(1) - ADDR_W'(len_eff);

  always_comb begin
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    done_nxt = done_r;
    if (in_acc && is_data) begin
      if (in_ch.last) begin
        pos_nxt  = '0;
        fill_nxt = '0;
        done_nxt = 1'b0;
      end else if (!done_r) begin
        pos_nxt  = pos_r + ADDR_W'(1);
        fill_nxt = fill_inc;
        done_nxt = hit;
      end
    end
  end

  always_comb begin
    len_nxt    = len_r;
    offset_nxt = offset_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_PATTERN_LENGTH: len_nxt    = cfg_ch.data[PLEN_W-1:0];
        REG_RESULT_OFFSET:  offset_nxt = cfg_ch.data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    if (emit_found || emit_nf) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = emit_found;
      out_addr_nxt  = emit_found ? start_addr : '0;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      offset_r    <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      offset_r    <= offset_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.match_address = out_addr_r;

  `WBPS_ASSERT_NEXT(a_emit_lands, emit_found || emit_nf, out_valid_r && (out_found_r == $past(emit_found)), "result not registered")
  `WBPS_ASSERT_NEXT(a_last_clears, in_acc && is_data && in_ch.last, (pos_r == '0) && (fill_r == '0) && !done_r, "last byte did not clear search")
  `WBPS_ASSERT_NEXT(a_done_frozen, done_r && in_acc && is_data && !in_ch.last, $stable(pos_r) && done_r, "search advanced after match")
  `WBPS_ASSERT_SAME(a_stall_blocks, out_valid_r && !out_ch.ready, !in_ch.ready, "item taken while result is stalled")

endmodule

// ===== src/wbps_cell.sv =====
// One compare cell: a window byte in the shift chain and one pattern byte.
// Depends on wbps_pkg.
module wbps_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wbps_pkg::wbps_cell_ctrl_t     ctrl,
  input  logic [wbps_pkg::BYTE_W-1:0]   win_in,
  input  logic [wbps_pkg::BYTE_W-1:0]   al_byte,
  output logic [wbps_pkg::BYTE_W-1:0]   win_out,
  output logic                          flag
);
  import wbps_pkg::*;

  logic [BYTE_W-1:0] win_r, win_nxt;
  logic [BYTE_W-1:0] pat_r, pat_nxt;
  logic              pat_we;

  assign pat_we  = ctrl.pat_wr && (int'(ctrl.wr_idx) == CELL_IDX);
  assign win_nxt = ctrl.shift ? win_in : win_r;
  assign pat_nxt = pat_we ? ctrl.wr_byte : pat_r;

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
    end else begin
      pat_r <= pat_nxt;
    end
  end

  // cells past the pattern length always pass
  assign flag = (int'(ctrl.len) <= CELL_IDX) || (pat_r == WILDCARD) || (al_byte == pat_r);

  assign win_out = win_r;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for wildcard_byte_pattern_search_core: directed cases,
// back-pressure and randomized search traffic, all checked against an in-bench predictor.
// Depends on wbps_pkg, the wbps channel interfaces and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wbps_pkg::*;

  localparam int unsigned DEPTH        = MAX_PATTERN_DEF;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } outcome_t;

  logic clk;
  logic rst_n;

  wbps_in_if  in_ch();
  wbps_out_if out_ch();
  wbps_cfg_if cfg_ch();

  wildcard_byte_pattern_search_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // predictor state
  logic [BYTE_W-1:0] pat_bytes [DEPTH];
  logic [BYTE_W-1:0] win_bytes [DEPTH];
  logic [31:0]       byte_pos;
  logic              hit_seen;
  int unsigned       win_fill;
  logic [PLEN_W-1:0] cur_plen;
  logic [ADDR_W-1:0] cur_offset;
  outcome_t          pending_outcomes [$];

  int fail_count     = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_seq       = 0;
  int hold_len       = 0;

  function automatic void clear_window();
    foreach (win_bytes[k]) win_bytes[k] = '0;
    byte_pos = '0;
    win_fill = 0;
    hit_seen = 1'b0;
  endfunction

  function automatic void advance_search(input logic act, input logic [PIDX_W-1:0] idx,
                                         input logic [BYTE_W-1:0] val, input logic lst);
    int unsigned len;
    int unsigned k;
    bit          hit;
    bit          ok;
    logic [31:0] start;
    outcome_t    res;
    hit = 1'b0;
    start = '0;
    if (act == ACT_PATTERN) begin
      pat_bytes[idx] = val;
      return;
    end
    if (!hit_seen) begin
      len = (cur_plen > DEPTH) ? DEPTH : cur_plen;
      for (k = DEPTH - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
      win_bytes[0] = val;
      if (win_fill < DEPTH) win_fill++;
      if (len == 0) begin
        hit = 1'b1;
      end else if (win_fill >= len) begin
        ok = 1'b1;
        for (k = 0; k < len; k++)
          if (pat_bytes[k] != WILDCARD && win_bytes[len-1-k] != pat_bytes[k]) ok = 1'b0;
        if (ok) begin
          hit = 1'b1;
          start = byte_pos - (len - 1);
        end
      end
      if (hit) begin
        res.found = 1'b1;
        res.addr = start + cur_offset;
        pending_outcomes.push_back(res);
        hit_seen = 1'b1;
      end
      byte_pos++;
    end
    if (lst) begin
      if (!hit_seen) begin
        res.found = 1'b0;
        res.addr = '0;
        pending_outcomes.push_back(res);
      end
      clear_window();
    end
  endfunction

  // prediction first, then checking, so a same-edge result still finds its expectation
  always @(posedge clk) begin
    outcome_t exp_res;
    if (!rst_n) begin
      foreach (pat_bytes[k]) pat_bytes[k] = '0;
      clear_window();
      cur_plen = '0;
      cur_offset = '0;
      pending_outcomes.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_PATTERN_LENGTH) cur_plen = cfg_ch.data[PLEN_W-1:0];
        else if (cfg_ch.index == REG_RESULT_OFFSET) cur_offset = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready)
        advance_search(in_ch.action, in_ch.pattern_index, in_ch.byte_value, in_ch.last);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected result found=%b addr=%h", $time,
                   out_ch.found, out_ch.match_address);
          fail_count++;
        end else begin
          exp_res = pending_outcomes.pop_front();
          if (out_ch.found !== exp_res.found) begin
            $display("%0t: found mismatch, expected %b actual %b", $time,
                     exp_res.found, out_ch.found);
            fail_count++;
          end
          if (out_ch.match_address !== exp_res.addr) begin
            $display("%0t: match_address mismatch, expected %h actual %h", $time,
                     exp_res.addr, out_ch.match_address);
            fail_count++;
          end
        end
      end
    end
  end

  // result side: random stalls, plus long hold-offs requested through hold_seq
  initial begin
    int seen_hold;
    int hold_left;
    seen_hold = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen_hold) begin
        seen_hold = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic act, input logic [PIDX_W-1:0] idx,
                           input logic [BYTE_W-1:0] val, input logic lst);
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.pattern_index <= idx;
    in_ch.byte_value <= val;
    in_ch.last <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_until_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // half the bytes come from a tiny alphabet so chance matches happen
  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(99) < 50) return BYTE_W'($urandom_range(0, 3));
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic test_empty_pattern();
    write_reg(REG_PATTERN_LENGTH, '0);
    write_reg(REG_RESULT_OFFSET, '0);
    send_item(ACT_DATA, 5'd0, 8'h00, 1'b0);
    send_item(ACT_DATA, 5'd31, 8'hFF, 1'b0);   // ignored after the match
    send_item(ACT_DATA, 5'd0, 8'h12, 1'b1);    // closes the search silently
    send_item(ACT_DATA, 5'd0, 8'hAB, 1'b1);    // last byte is itself the match
    wait_until_idle();
  endtask

  task automatic test_wildcard_match();
    send_item(ACT_PATTERN, 5'd0, 8'hA5, 1'b0);
    send_item(ACT_PATTERN, 5'd1, WILDCARD, 1'b1);
    send_item(ACT_PATTERN, 5'd31, 8'h5A, 1'b0);
    wait_until_idle();
    write_reg(REG_PATTERN_LENGTH, 32'd2);
    write_reg(REG_RESULT_OFFSET, 32'hFFFF_FFFF);   // address wraps to zero
    send_item(ACT_DATA, 5'd0, 8'h00, 1'b0);
    send_item(ACT_DATA, 5'd0, 8'hA5, 1'b0);
    send_item(ACT_DATA, 5'd0, 8'hFF, 1'b0);
    send_item(ACT_DATA, 5'd0, 8'h77, 1'b1);
    wait_until_idle();
  endtask

  task automatic test_no_match();
    send_item(ACT_DATA, 5'd0, 8'hA5, 1'b1);    // window shorter than pattern
    send_item(ACT_DATA, 5'd0, 8'h11, 1'b0);
    send_item(ACT_DATA, 5'd0, 8'h22, 1'b1);
    wait_until_idle();
  endtask

  task automatic test_write_during_search();
    send_item(ACT_DATA, 5'd0, 8'h33, 1'b0);
    send_item(ACT_PATTERN, 5'd0, 8'h33, 1'b0);
    send_item(ACT_DATA, 5'd0, 8'h44, 1'b1);
    wait_until_idle();
  endtask

  task automatic test_length_clamp();
    write_reg(REG_PATTERN_LENGTH, 32'd63);
    write_reg(REG_RESULT_OFFSET, 32'h1234_5678);
    send_item(ACT_DATA, 5'd0, 8'h00, 1'b0);
    send_item(ACT_DATA, 5'd0, 8'h00, 1'b1);
    wait_until_idle();
  endtask

  task automatic test_backpressure();
    int k;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_PATTERN_LENGTH, '0);
    hold_len = 80;
    hold_seq++;
    // every item is a one-byte search that hits, so the output backs up fast
    for (k = 0; k < 12; k++) send_item(ACT_DATA, PIDX_W'(k), BYTE_W'($urandom), 1'b1);
    wait_until_idle();
  endtask

  task automatic run_random_search();
    logic [BYTE_W-1:0]     pat_copy [DEPTH];
    logic [CFG_DATA_W-1:0] wdata;
    logic [BYTE_W-1:0]     b;
    logic [PIDX_W-1:0]     widx;
    int unsigned           plen_eff;
    int unsigned           slen;
    int unsigned           plant_at;
    int unsigned           i;
    int unsigned           r;
    bit                    planted;
    pat_copy = pat_bytes;
    if ($urandom_range(99) < 30) begin
      wait_until_idle();
      r = $urandom_range(99);
      wdata = $urandom;
      if (r < 8) wdata[PLEN_W-1:0] = '0;
      else if (r < 16) wdata[PLEN_W-1:0] = PLEN_W'(DEPTH);
      else if (r < 22) wdata[PLEN_W-1:0] = PLEN_W'($urandom_range(DEPTH + 1, 63));
      else wdata[PLEN_W-1:0] = PLEN_W'($urandom_range(1, 6));
      write_reg(REG_PATTERN_LENGTH, wdata);
      r = $urandom_range(99);
      if (r < 15) wdata = '0;
      else if (r < 30) wdata = '1;
      else if (r < 45) wdata = 32'hFFFF_FFFF - $urandom_range(0, 40);
      else wdata = $urandom;
      write_reg(REG_RESULT_OFFSET, wdata);
    end
    plen_eff = (cur_plen > DEPTH) ? DEPTH : cur_plen;
    for (i = 0; i < plen_eff; i++) begin
      if ($urandom_range(99) < 50) begin
        b = ($urandom_range(99) < 25) ? WILDCARD : pick_byte();
        pat_copy[i] = b;
        send_item(ACT_PATTERN, PIDX_W'(i), b, 1'($urandom_range(1)));
      end
    end
    if ($urandom_range(99) < 20) begin
      widx = PIDX_W'($urandom);
      b = pick_byte();
      pat_copy[widx] = b;
      send_item(ACT_PATTERN, widx, b, 1'($urandom_range(1)));
    end
    if (plen_eff == 0) slen = $urandom_range(1, 4);
    else if ($urandom_range(99) < 10) slen = $urandom_range(1, plen_eff);
    else slen = plen_eff + $urandom_range(0, 16);
    planted = (plen_eff > 0) && (slen >= plen_eff) && ($urandom_range(99) < 70);
    plant_at = planted ? $urandom_range(0, slen - plen_eff) : 0;
    for (i = 0; i < slen; i++) begin
      if ($urandom_range(99) < 4) begin
        widx = PIDX_W'($urandom);
        b = pick_byte();
        pat_copy[widx] = b;
        send_item(ACT_PATTERN, widx, b, 1'($urandom_range(1)));
      end
      b = pick_byte();
      if (planted && i >= plant_at && i < plant_at + plen_eff
          && pat_copy[i - plant_at] != WILDCARD)
        b = pat_copy[i - plant_at];
      send_item(ACT_DATA, PIDX_W'($urandom), b, i == slen - 1);
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
    int target;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    target = items_sent + n_items;
    while (items_sent < target) run_random_search();
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0, 300);
    run_phase(79, 0, 270);
    run_phase(0, 79, 270);
    run_phase(6, 6, 270);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_PATTERN;
    in_ch.pattern_index = '0;
    in_ch.byte_value = '0;
    in_ch.last = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_PATTERN_LENGTH;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_pattern();
    test_wildcard_match();
    test_no_match();
    test_write_during_search();
    test_length_clamp();
    test_backpressure();
    test_random_traffic();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_until_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== wildcard_byte_pattern_search_core.f =====
+incdir+src
src/wbps_pkg.sv
src/wbps_if.sv
src/wbps_cell.sv
src/wildcard_byte_pattern_search_core.sv
tb/testbench.sv
